// ===== sv/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length decode iterator.
// ----------------------------------------------------------------------------
`default_nettype none

package rld_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_NEXT   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE    = 1'b0,
		ST_NEXT_WB = 1'b1
	} state_t;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

endpackage

`default_nettype wire

// ===== sv/run_length_decode_iterator.sv =====
// ----------------------------------------------------------------------------
// run_length_decode_iterator
// Loads letter/digit text into a letter and count table, then hands out
// one decoded letter per next command.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: command and byte_in are taken at a clock edge with
//    start high and busy low. Command 0 appends a byte, 1 requests the next
//    letter, 2 clears the table; any other code is a no-op.
//  - Result channel: done is high for exactly one cycle per command, with
//    letter_out, has_more and overflow valid in that cycle. The receiver
//    cannot stall; results are not held.
//  - Append, clear and no-op: result in the cycle after the accepting edge;
//    next command may follow back to back.
//  - Next: the table entry is read from the synchronous table memory at the
//    accepting edge; in the ST_NEXT_WB state that follows, busy is high, the
//    count is decremented and written back and the result is registered.
//  - A pending entry committed by a next request is forwarded when it is the
//    entry being read in the same beat.
//  - Reset empties the table, pending entry and overflow flag at once; the
//    table memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_decode_iterator
	import rld_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int COUNT_BITS  = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] command,
	input  wire logic [7:0] byte_in,
	output logic            done,
	output logic [7:0]      letter_out,
	output logic            has_more,
	output logic            overflow
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = COUNT_BITS;
	localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);

	logic [7:0]    letter_mem [TABLE_DEPTH];
	logic [CW-1:0] count_mem  [TABLE_DEPTH];

	state_t        state_q, state_d;
	logic [PW-1:0] fill_q, read_q;
	logic          in_digits_q;
	logic [7:0]    pend_letter_q;
	logic [CW-1:0] pend_count_q;
	logic          ovf_q;
	logic          done_q;
	logic [7:0]    letter_q;

	logic [7:0]    rd_letter_s1, fwd_letter_s1;
	logic [CW-1:0] rd_count_s1, fwd_count_s1;
	logic          fwd_s1, empty_s1;

	logic          accept, is_digit, pend_live, room, digit_step;
	logic          commit_wr, commit_ovf, wb_wr;
	logic [PW-1:0] fill_after;
	logic [CW+3:0] count_ext;
	logic          count_sat;
	logic [7:0]    cur_letter;
	logic [CW-1:0] cur_count, cnt_dec;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] wr_count;

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && command == CMD_NEXT) begin
					state_d = ST_NEXT_WB;
				end
			end
			ST_NEXT_WB: begin
				busy    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				busy    = 1'b1;
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		accept     = start && !busy;
		is_digit   = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
		pend_live  = in_digits_q && (pend_count_q != '0);
		room       = fill_q < DEPTH_P;
		digit_step = accept && command == CMD_APPEND && in_digits_q && is_digit;
		commit_wr  = accept && pend_live && room &&
			((command == CMD_APPEND && !digit_step) || command == CMD_NEXT);
		commit_ovf = accept && pend_live && !room &&
			((command == CMD_APPEND && !digit_step) || command == CMD_NEXT);
		fill_after = fill_q + PW'(commit_wr);

		count_ext = ({4'b0, pend_count_q} << 3) + ({4'b0, pend_count_q} << 1)
			+ (CW+4)'(byte_in[3:0]);
		count_sat = count_ext[CW+3:CW] != 4'b0;

		cur_letter = fwd_s1 ? fwd_letter_s1 : rd_letter_s1;
		cur_count  = fwd_s1 ? fwd_count_s1 : rd_count_s1;
		cnt_dec    = cur_count - CW'(1);
		wb_wr      = (state_q == ST_NEXT_WB) && !empty_s1;

		wr_addr  = commit_wr ? fill_q[AW-1:0] : read_q[AW-1:0];
		wr_count = commit_wr ? pend_count_q : cnt_dec;
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (commit_wr) begin
			letter_mem[wr_addr] <= pend_letter_q;
		end
		if (commit_wr || wb_wr) begin
			count_mem[wr_addr] <= wr_count;
		end
		rd_letter_s1 <= letter_mem[read_q[AW-1:0]];
		rd_count_s1  <= count_mem[read_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_letter_s1 <= pend_letter_q;
			fwd_count_s1  <= pend_count_q;
			fwd_s1        <= commit_wr && (read_q == fill_q);
			empty_s1      <= read_q >= fill_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			read_q        <= '0;
			in_digits_q   <= 1'b0;
			pend_letter_q <= CHAR_NONE;
			pend_count_q  <= '0;
			ovf_q         <= 1'b0;
			done_q        <= 1'b0;
			letter_q      <= CHAR_NONE;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (command != CMD_NEXT) begin
					done_q   <= 1'b1;
					letter_q <= CHAR_NONE;
				end
				case (command)
					CMD_APPEND: begin
						if (digit_step) begin
							if (count_sat) begin
								pend_count_q <= '1;
								ovf_q        <= 1'b1;
							end else begin
								pend_count_q <= count_ext[CW-1:0];
							end
						end else begin
							fill_q        <= fill_after;
							in_digits_q   <= 1'b1;
							pend_letter_q <= byte_in;
							pend_count_q  <= '0;
							if (commit_ovf) begin
								ovf_q <= 1'b1;
							end
						end
					end
					CMD_NEXT: begin
						fill_q        <= fill_after;
						in_digits_q   <= 1'b0;
						pend_letter_q <= CHAR_NONE;
						pend_count_q  <= '0;
						if (commit_ovf) begin
							ovf_q <= 1'b1;
						end
					end
					CMD_CLEAR: begin
						fill_q        <= '0;
						read_q        <= '0;
						in_digits_q   <= 1'b0;
						pend_letter_q <= CHAR_NONE;
						pend_count_q  <= '0;
						ovf_q         <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (state_q == ST_NEXT_WB) begin
				done_q <= 1'b1;
				if (empty_s1) begin
					letter_q <= CHAR_SPACE;
				end else begin
					letter_q <= cur_letter;
					if (cnt_dec == '0) begin
						read_q <= read_q + PW'(1);
					end
				end
			end
		end
	end

	assign done       = done_q;
	assign letter_out = letter_q;
	assign has_more   = (read_q < fill_q) || (pend_live && room);
	assign overflow   = ovf_q;

endmodule

`default_nettype wire

// ===== sv/rld_checker.sv =====
// ----------------------------------------------------------------------------
// rld_checker
// Port-level timing checks for the run-length decode iterator.
// ----------------------------------------------------------------------------
`default_nettype none

module rld_checker
	import rld_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] command,
	input wire logic       done,
	input wire logic [7:0] letter_out,
	input wire logic       has_more,
	input wire logic       overflow
);

	a_short_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command != CMD_NEXT |=> done && letter_out == CHAR_NONE)
		else $error("append/clear beat without result next cycle");

	a_next_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_NEXT |=> busy && !done ##1 done && !busy)
		else $error("next beat timing wrong");

	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_CLEAR |=> !overflow && !has_more)
		else $error("clear left state behind");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start && !busy))
		else $error("result without a command");

endmodule

bind run_length_decode_iterator rld_checker u_rld_checker (.*);

`default_nettype wire
